/* hdl/nolp_pkg.sv */
// package for the obstacle line parser: phase codes, sizes and number helpers
// no dependencies
`default_nettype none
package nolp_pkg;
    localparam int LINE_LIMIT   = 256;
    localparam int COLOUR_CHARS = 7;
    localparam int CNT_W = $clog2(LINE_LIMIT);
    localparam int CLEN_W = $clog2(COLOUR_CHARS + 1);

    typedef logic [3:0] t_nav_phase;
    localparam t_nav_phase NAV_FAIL = 4'd15;
    typedef logic [4:0] t_obst_phase;
    localparam t_obst_phase OB_DONE_VAL  = 5'd12;
    localparam t_obst_phase OB_DONE_NONE = 5'd13;
    localparam t_obst_phase OB_FAIL      = 5'd14;

    localparam logic [1:0] NUM_PRE = 2'd0, NUM_SIGN = 2'd1, NUM_DIG = 2'd2,
                           NUM_END = 2'd3;
    localparam logic [1:0] COL_NONE = 2'd0, COL_RED = 2'd1, COL_GREEN = 2'd2;

    typedef struct packed {
        logic [1:0]  sub;
        logic        bad;
        logic        neg;
        logic [31:0] acc;
    } t_num;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [31:0] finish_num(input logic [31:0] mag, input logic neg);
        if (neg) return 32'd0 - mag;
        return (mag > 32'h7fffffff) ? 32'h7fffffff : mag;
    endfunction

    // one character into a scanf style integer
    function automatic t_num num_feed(input logic [7:0] c, input logic [1:0] sub,
                                      input logic [31:0] acc, input logic neg);
        t_num r;
        logic [35:0] m;
        r.sub = sub; r.bad = 1'b0; r.neg = neg; r.acc = acc;
        m = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {28'd0, c - 8'h30};
        if (sub == NUM_PRE && is_blank(c)) begin
            r.sub = NUM_PRE;
        end else if (sub == NUM_PRE && c == 8'h2b) begin
            r.sub = NUM_SIGN;
        end else if (sub == NUM_PRE && c == 8'h2d) begin
            r.sub = NUM_SIGN; r.neg = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.sub = NUM_DIG;
            r.acc = (m > 36'h080000000) ? 32'h80000000 : m[31:0];
        end else if (sub == NUM_DIG) begin
            r.sub = NUM_END;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/nav_obstacle_line_parser_unit.sv */
// serial line parser for NAV and OBST groups, one byte per cycle while input ready is high
// depends on nolp_pkg
// One byte is taken per ready cycle; the parser state and accumulators update in that
// cycle, and a line feed after a non-empty line loads the result register, which is
// presented on the valid/ready output while the next bytes keep being accepted. Input
// ready drops only when a line feed arrives while an untaken result still waits.
`default_nettype none
module nav_obstacle_line_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_line_used,
    output logic [31:0]      o_left_command,
    output logic [31:0]      o_right_command,
    output logic [1:0]       o_obstacle_colour,
    output logic [31:0]      o_obstacle_distance,
    output logic [31:0]      o_obstacle_lateral,
    output logic             o_data_valid
);
    import nolp_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_ended, n_ended;
    t_nav_phase r_np, n_np;
    logic [31:0] r_na1, n_na1, r_na2, n_na2;
    logic r_nneg, n_nneg;
    t_obst_phase r_op, n_op;
    logic [2:0] r_cm, n_cm;
    logic [CLEN_W-1:0] r_cl, n_cl;
    logic [31:0] r_oa1, n_oa1, r_oa2, n_oa2;
    logic r_oneg, n_oneg;
    logic [31:0] r_hl, n_hl, r_hr, n_hr, r_hd, n_hd, r_hla, n_hla;
    logic [1:0] r_hc, n_hc;
    logic r_hv, n_hv;
    logic r_ov, n_ov, r_used, n_used;

    logic acc, is_lf;
    t_num nr, orr;
    logic [2:0] m;
    logic nav_ok, obst_ok;
    logic [7:0] c;

    assign c = i_rx_byte;
    assign is_lf = (c == 8'h0a);
    assign o_ready = !(is_lf && r_ov && !i_ready);
    assign acc = i_valid && o_ready;

    always_comb begin
        n_cnt = r_cnt; n_ended = r_ended;
        n_np = r_np; n_na1 = r_na1; n_na2 = r_na2; n_nneg = r_nneg;
        n_op = r_op; n_cm = r_cm; n_cl = r_cl;
        n_oa1 = r_oa1; n_oa2 = r_oa2; n_oneg = r_oneg;
        n_hl = r_hl; n_hr = r_hr; n_hc = r_hc; n_hd = r_hd; n_hla = r_hla; n_hv = r_hv;
        n_ov = r_ov && !i_ready; n_used = r_used;
        nr = num_feed(c, 2'd0, r_na1, r_nneg);
        orr = num_feed(c, 2'd0, r_oa1, r_oneg);
        m = r_cm;
        nav_ok = (r_np == 4'd13) || (r_np == 4'd14);
        obst_ok = (r_op == 5'd11) || (r_op == OB_DONE_VAL) || (r_op == OB_DONE_NONE);
        if (acc) begin
            if (is_lf || (c != 8'h0d && r_cnt == CNT_W'(LINE_LIMIT - 1))) begin
                if (is_lf && r_cnt != '0) begin
                    if (nav_ok) begin
                        n_hl = r_na1;
                        n_hr = finish_num(r_na2, r_nneg);
                    end
                    if (obst_ok) begin
                        if (r_op == OB_DONE_NONE) begin
                            n_hc = COL_NONE; n_hd = '0; n_hla = '0;
                        end else begin
                            if (r_cm[0] && r_cl == CLEN_W'(3)) n_hc = COL_RED;
                            else if (r_cm[1] && r_cl == CLEN_W'(5)) n_hc = COL_GREEN;
                            else n_hc = COL_NONE;
                            n_hd = r_oa1;
                            n_hla = finish_num(r_oa2, r_oneg);
                        end
                    end
                    if (nav_ok || obst_ok) n_hv = 1'b1;
                    n_used = nav_ok || obst_ok;
                    n_ov = 1'b1;
                end
                n_cnt = '0; n_ended = 1'b0;
                n_np = '0; n_na1 = '0; n_na2 = '0; n_nneg = 1'b0;
                n_op = '0; n_cm = '0; n_cl = '0; n_oa1 = '0; n_oa2 = '0; n_oneg = 1'b0;
            end else if (c != 8'h0d) begin
                n_cnt = r_cnt + 1'b1;
                if (!r_ended && c == 8'h00) n_ended = 1'b1;
                else if (!r_ended) begin
                    // nav group
                    if (r_np < 4'd4) begin
                        if ((r_np == 4'd0 && c == "N") || (r_np == 4'd1 && c == "A") ||
                            (r_np == 4'd2 && c == "V") || (r_np == 4'd3 && c == ":"))
                            n_np = r_np + 1'b1;
                        else n_np = (c == "N") ? 4'd1 : 4'd0;
                    end else begin
                        case (r_np)
                            4'd4: n_np = (c == "L") ? 4'd5 : NAV_FAIL;
                            4'd5: begin
                                if (c == "=") begin
                                    n_np = 4'd6; n_na1 = '0; n_nneg = 1'b0;
                                end else n_np = NAV_FAIL;
                            end
                            4'd6, 4'd7, 4'd8: begin
                                nr = num_feed(c, 2'(r_np - 4'd6), r_na1, r_nneg);
                                n_na1 = nr.acc; n_nneg = nr.neg;
                                if (!nr.bad && nr.sub != NUM_END) n_np = 4'd6 + 4'(nr.sub);
                                else if (!nr.bad && c == ",") begin
                                    n_na1 = finish_num(r_na1, r_nneg); n_np = 4'd9;
                                end else n_np = NAV_FAIL;
                            end
                            4'd9: n_np = (c == "R") ? 4'd10 : NAV_FAIL;
                            4'd10: begin
                                if (c == "=") begin
                                    n_np = 4'd11; n_na2 = '0; n_nneg = 1'b0;
                                end else n_np = NAV_FAIL;
                            end
                            4'd11, 4'd12, 4'd13: begin
                                nr = num_feed(c, 2'(r_np - 4'd11), r_na2, r_nneg);
                                n_na2 = nr.acc; n_nneg = nr.neg;
                                if (!nr.bad && nr.sub != NUM_END) n_np = 4'd11 + 4'(nr.sub);
                                else n_np = nr.bad ? NAV_FAIL : 4'd14;
                            end
                            default: ;
                        endcase
                    end
                    // obstacle group
                    if (r_op < 5'd5) begin
                        if ((r_op == 5'd0 && c == "O") || (r_op == 5'd1 && c == "B") ||
                            (r_op == 5'd2 && c == "S") || (r_op == 5'd3 && c == "T") ||
                            (r_op == 5'd4 && c == ":"))
                            n_op = r_op + 1'b1;
                        else n_op = (c == "O") ? 5'd1 : 5'd0;
                        if (n_op == 5'd5) begin
                            n_cm = 3'd7; n_cl = '0;
                        end
                    end else begin
                        case (r_op)
                            5'd5: begin
                                if (c == ",") begin
                                    if (r_cl != '0) begin
                                        n_op = 5'd6; n_oa1 = '0; n_oneg = 1'b0;
                                    end else n_op = OB_FAIL;
                                end else if (r_cl < CLEN_W'(COLOUR_CHARS)) begin
                                    if (!((r_cl == 0 && c == "R") || (r_cl == 1 && c == "E") ||
                                          (r_cl == 2 && c == "D"))) m[0] = 1'b0;
                                    if (!((r_cl == 0 && c == "G") || (r_cl == 1 && c == "R") ||
                                          (r_cl == 2 && c == "E") || (r_cl == 3 && c == "E") ||
                                          (r_cl == 4 && c == "N"))) m[1] = 1'b0;
                                    if (!((r_cl == 0 && c == "N") || (r_cl == 1 && c == "O") ||
                                          (r_cl == 2 && c == "N") || (r_cl == 3 && c == "E")))
                                        m[2] = 1'b0;
                                    n_cm = m;
                                    n_cl = r_cl + 1'b1;
                                    if (m[2] && r_cl == CLEN_W'(3)) n_op = OB_DONE_NONE;
                                end else n_op = OB_FAIL;
                            end
                            5'd6, 5'd7, 5'd8: begin
                                orr = num_feed(c, 2'(r_op - 5'd6), r_oa1, r_oneg);
                                n_oa1 = orr.acc; n_oneg = orr.neg;
                                if (!orr.bad && orr.sub != NUM_END) n_op = 5'd6 + 5'(orr.sub);
                                else if (!orr.bad && c == ",") begin
                                    n_oa1 = finish_num(r_oa1, r_oneg); n_op = 5'd9;
                                    n_oa2 = '0; n_oneg = 1'b0;
                                end else n_op = OB_FAIL;
                            end
                            5'd9, 5'd10, 5'd11: begin
                                orr = num_feed(c, 2'(r_op - 5'd9), r_oa2, r_oneg);
                                n_oa2 = orr.acc; n_oneg = orr.neg;
                                if (!orr.bad && orr.sub != NUM_END) n_op = 5'd9 + 5'(orr.sub);
                                else n_op = orr.bad ? OB_FAIL : OB_DONE_VAL;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_ended <= 1'b0; r_np <= '0; r_na1 <= '0; r_na2 <= '0;
            r_nneg <= 1'b0; r_op <= '0; r_cm <= '0; r_cl <= '0; r_oa1 <= '0;
            r_oa2 <= '0; r_oneg <= 1'b0; r_hl <= '0; r_hr <= '0; r_hc <= '0;
            r_hd <= '0; r_hla <= '0; r_hv <= 1'b0; r_ov <= 1'b0; r_used <= 1'b0;
        end else begin
            r_cnt <= n_cnt; r_ended <= n_ended; r_np <= n_np; r_na1 <= n_na1;
            r_na2 <= n_na2; r_nneg <= n_nneg; r_op <= n_op; r_cm <= n_cm; r_cl <= n_cl;
            r_oa1 <= n_oa1; r_oa2 <= n_oa2; r_oneg <= n_oneg; r_hl <= n_hl; r_hr <= n_hr;
            r_hc <= n_hc; r_hd <= n_hd; r_hla <= n_hla; r_hv <= n_hv; r_ov <= n_ov;
            r_used <= n_used;
        end
    end

    assign o_valid = r_ov;
    assign o_line_used = r_used;
    assign o_left_command = r_hl;
    assign o_right_command = r_hr;
    assign o_obstacle_colour = r_hc;
    assign o_obstacle_distance = r_hd;
    assign o_obstacle_lateral = r_hla;
    assign o_data_valid = r_hv;

    a_used_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_used |-> r_hv) else $error("used line without data valid");
    a_colour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc != 2'd3) else $error("bad colour code");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && is_lf && r_cnt != '0 && r_op == OB_DONE_NONE |=> r_hd == '0 && r_hla == '0)
        else $error("none did not clear obstacle");
    a_lf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && is_lf |=> r_cnt == '0 && r_np == '0 && r_op == '0)
        else $error("line end did not clear");
endmodule
`default_nettype wire

/* bench/nav_obstacle_line_parser_unit_tb.sv */
// testbench for nav_obstacle_line_parser_unit: byte stream in, parsed line results out
// depends on nolp_pkg and the unit; holds its own line parser and a small result checker
`timescale 1ns / 100ps

class line_result_checker;
    logic [131:0] pending_lines[$];
    int mismatches;
    int unexpected;

    function void note_line(logic [131:0] r);
        pending_lines.push_back(r);
    endfunction

    function void check_line(logic [131:0] got);
        logic [131:0] want;
        if (pending_lines.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = pending_lines.pop_front();
        if (want !== got) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("mismatch expected %h actual %h", want, got);
        end
    endfunction
endclass

module nav_obstacle_line_parser_unit_tb;
    import nolp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_line_used, o_data_valid;
    logic [31:0] o_left_command, o_right_command, o_obstacle_distance, o_obstacle_lateral;
    logic [1:0]  o_obstacle_colour;

    nav_obstacle_line_parser_unit dut (.*);

    always #2 i_clk = ~i_clk;

    line_result_checker results = new();
    int cycles;
    int stall_mode;

    // predictor state
    int unsigned stored_bytes;
    bit          text_done;
    int unsigned nav_ph, obst_ph, col_len;
    logic [31:0] nav_a, nav_b, ob_a, ob_b;
    bit          nav_neg, ob_neg;
    logic [2:0]  col_hits;
    logic [31:0] keep_left, keep_right, keep_dist, keep_lat;
    logic [1:0]  keep_colour;
    bit          keep_valid;

    function automatic logic [31:0] sat_value(logic [31:0] mag, bit neg);
        if (neg) return 32'd0 - mag;
        return (mag > 32'h7fffffff) ? 32'h7fffffff : mag;
    endfunction

    // scanf style digit step; 0 pre, 1 signed, 2 digits, 3 ended, 4 bad
    function automatic int digit_step(logic [7:0] c, int sub, ref logic [31:0] acc,
                                      ref bit neg);
        logic [63:0] m;
        if (sub == 0) begin
            if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) return 0;
            if (c == "+") return 1;
            if (c == "-") begin neg = 1'b1; return 1; end
        end
        if (!(c >= "0" && c <= "9")) return (sub == 2) ? 3 : 4;
        m = {32'd0, acc} * 10 + (c - 8'h30);
        if (m > 64'h80000000) m = 64'h80000000;
        acc = m[31:0];
        return 2;
    endfunction

    task automatic clear_line();
        stored_bytes = 0; text_done = 0;
        nav_ph = 0; nav_a = 0; nav_b = 0; nav_neg = 0;
        obst_ph = 0; col_hits = 0; col_len = 0; ob_a = 0; ob_b = 0; ob_neg = 0;
    endtask

    task automatic scan_nav(logic [7:0] c);
        logic [7:0] kw[4] = '{"N", "A", "V", ":"};
        int r;
        if (nav_ph < 4) begin
            if (c == kw[nav_ph]) nav_ph++;
            else nav_ph = (c == "N") ? 1 : 0;
            return;
        end
        case (nav_ph)
            4: nav_ph = (c == "L") ? 5 : NAV_FAIL;
            5: if (c == "=") begin nav_ph = 6; nav_a = 0; nav_neg = 0; end
               else nav_ph = NAV_FAIL;
            6, 7, 8: begin
                r = digit_step(c, nav_ph - 6, nav_a, nav_neg);
                if (r < 3) nav_ph = 6 + r;
                else if (r == 3 && c == ",") begin
                    nav_a = sat_value(nav_a, nav_neg); nav_ph = 9;
                end else nav_ph = NAV_FAIL;
            end
            9: nav_ph = (c == "R") ? 10 : NAV_FAIL;
            10: if (c == "=") begin nav_ph = 11; nav_b = 0; nav_neg = 0; end
                else nav_ph = NAV_FAIL;
            11, 12, 13: begin
                r = digit_step(c, nav_ph - 11, nav_b, nav_neg);
                if (r < 3) nav_ph = 11 + r;
                else nav_ph = (r == 3) ? 14 : NAV_FAIL;
            end
            default: ;
        endcase
    endtask

    task automatic scan_obst(logic [7:0] c);
        logic [7:0] kw[5] = '{"O", "B", "S", "T", ":"};
        logic [7:0] red[3] = '{"R", "E", "D"};
        logic [7:0] grn[5] = '{"G", "R", "E", "E", "N"};
        logic [7:0] non[4] = '{"N", "O", "N", "E"};
        logic [2:0] m;
        int r;
        if (obst_ph < 5) begin
            if (c == kw[obst_ph]) obst_ph++;
            else obst_ph = (c == "O") ? 1 : 0;
            if (obst_ph == 5) begin col_hits = 3'd7; col_len = 0; end
            return;
        end
        case (obst_ph)
            5: if (c == ",") begin
                if (col_len >= 1) begin obst_ph = 6; ob_a = 0; ob_neg = 0; end
                else obst_ph = OB_FAIL;
            end else if (col_len < COLOUR_CHARS) begin
                m = col_hits;
                if (!(col_len < 3 && c == red[col_len])) m &= 3'd6;
                if (!(col_len < 5 && c == grn[col_len])) m &= 3'd5;
                if (!(col_len < 4 && c == non[col_len])) m &= 3'd3;
                col_hits = m; col_len++;
                if (m[2] && col_len == 4) obst_ph = OB_DONE_NONE;
            end else obst_ph = OB_FAIL;
            6, 7, 8: begin
                r = digit_step(c, obst_ph - 6, ob_a, ob_neg);
                if (r < 3) obst_ph = 6 + r;
                else if (r == 3 && c == ",") begin
                    ob_a = sat_value(ob_a, ob_neg); obst_ph = 9; ob_b = 0; ob_neg = 0;
                end else obst_ph = OB_FAIL;
            end
            9, 10, 11: begin
                r = digit_step(c, obst_ph - 9, ob_b, ob_neg);
                if (r < 3) obst_ph = 9 + r;
                else obst_ph = (r == 3) ? OB_DONE_VAL : OB_FAIL;
            end
            default: ;
        endcase
    endtask

    task automatic predict_byte(logic [7:0] c);
        bit nav_ok, obst_ok;
        if (c == 8'h0a) begin
            if (stored_bytes > 0) begin
                nav_ok = nav_ph == 13 || nav_ph == 14;
                obst_ok = obst_ph == 11 || obst_ph == OB_DONE_VAL || obst_ph == OB_DONE_NONE;
                if (nav_ok) begin
                    keep_left = nav_a; keep_right = sat_value(nav_b, nav_neg);
                end
                if (obst_ok) begin
                    if (obst_ph == OB_DONE_NONE) begin
                        keep_colour = COL_NONE; keep_dist = 0; keep_lat = 0;
                    end else begin
                        if (col_hits[0] && col_len == 3) keep_colour = COL_RED;
                        else if (col_hits[1] && col_len == 5) keep_colour = COL_GREEN;
                        else keep_colour = COL_NONE;
                        keep_dist = ob_a; keep_lat = sat_value(ob_b, ob_neg);
                    end
                end
                if (nav_ok || obst_ok) keep_valid = 1;
                results.note_line({nav_ok || obst_ok, keep_left, keep_right, keep_colour,
                                   keep_dist, keep_lat, keep_valid});
            end
            clear_line();
        end else if (c != 8'h0d) begin
            if (stored_bytes < LINE_LIMIT - 1) begin
                stored_bytes++;
                if (!text_done) begin
                    if (c == 8'h00) text_done = 1;
                    else begin scan_nav(c); scan_obst(c); end
                end
            end else clear_line();
        end
    endtask

    // one byte, honoring burst gaps
    int burst_left;
    task automatic send_byte(logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_rx_byte <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_byte(c);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    function automatic string rand_int();
        string s;
        int pick;
        pick = $urandom_range(0, 9);
        s = "";
        if (pick == 0) s = " \t";
        if (pick == 1) s = "+";
        if (pick == 2) s = "-";
        if (pick == 3) return "99999999999";
        if (pick == 4) return "-2147483648";
        if (pick == 5) return "2147483647";
        if (pick == 6) return "x";
        return $sformatf("%s%0d", s, $urandom_range(0, 100000));
    endfunction

    function automatic string rand_colour();
        case ($urandom_range(0, 5))
            0: return "RED";
            1: return "GREEN";
            2: return "BLUE";
            3: return "REDX";
            4: return "ABCDEFGH";
            default: return "";
        endcase
    endfunction

    function automatic string rand_line();
        string s;
        s = "";
        if ($urandom_range(0, 3) == 0) s = "ab";
        if ($urandom_range(0, 2) != 0)
            s = {s, "NAV:L=", rand_int(), ",R=", rand_int(), ";"};
        case ($urandom_range(0, 3))
            0: s = {s, "OBST:NONE"};
            1, 2: s = {s, "OBST:", rand_colour(), ",", rand_int(), ",", rand_int()};
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) s = {s, "\r"};
        return {s, "\n"};
    endfunction

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_mode == 0) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0) && (cycles % 64 < 48);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready)
            results.check_line({o_line_used, o_left_command, o_right_command,
                                o_obstacle_colour, o_obstacle_distance,
                                o_obstacle_lateral, o_data_valid});
        if (cycles > CYCLE_LIMIT) begin
            $display("nav_obstacle_line_parser_unit_tb failed");
            $finish;
        end
    end

    initial begin
        string s;
        clear_line();
        keep_left = 0; keep_right = 0; keep_dist = 0; keep_lat = 0;
        keep_colour = 0; keep_valid = 0;
        cycles = 0; stall_mode = 0; burst_left = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed lines
        send_text("\n\r\nhello\n");
        send_text("NAV:L=-12,R=+34\n");
        send_text("OBST:RED,100,-5\r\n");
        send_text("OBST:GREEN, 7,\t8 tail\n");
        send_text("OBST:NONEXYZ\n");
        send_text("NAV:L=99999999999,R=-99999999999 OBST:BLUE,1,2\n");
        send_text("NAV:X NAV:L=1,R=2\n");
        send_text("OBST:TOOLONGC,1,2\n");
        send_text("OBST:,1,2\n");
        send_text("NA");
        send_byte(8'h00);
        send_text("NAV:L=3,R=4\n");
        send_byte(8'hff); send_byte(8'h80); send_byte(8'h0a);
        for (int k = 0; k < 300; k++) send_byte("x");
        send_text("NAV:L=5,R=6\n");
        stall_mode = 1;
        for (int n = 0; n < 1100; ) begin
            if ($urandom_range(0, 9) == 0) begin
                s = "";
                repeat ($urandom_range(1, 12)) s = {s, string'(8'($urandom_range(0, 255)))};
            end else s = rand_line();
            n += s.len();
            send_text(s);
            if (n > 800) stall_mode = (n / 200) % 2;
        end
        send_text("\n");
        i_valid <= 1'b0;
        while (results.pending_lines.size() != 0 && cycles < CYCLE_LIMIT)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (results.mismatches == 0 && results.unexpected == 0
            && results.pending_lines.size() == 0)
            $display("nav_obstacle_line_parser_unit_tb passed");
        else
            $display("nav_obstacle_line_parser_unit_tb failed");
        $finish;
    end
endmodule

/* files.f */
hdl/nolp_pkg.sv
hdl/nav_obstacle_line_parser_unit.sv
bench/nav_obstacle_line_parser_unit_tb.sv
